// ===== sv/srp_pkg.sv =====
// Package for the shelf rectangle packer: codes, field widths, defaults and
// the word and configuration structs shared by the modules of the block.
// Depends on nothing.
`default_nettype none

package srp_pkg;

  localparam int SRP_COORD_BITS    = 16;
  localparam int SRP_DIM_BITS      = 15;
  localparam int SRP_OUT_BITS      = 16;
  localparam int SRP_DEFAULT_ATLAS = 512;
  localparam int SRP_DEFAULT_MAX   = 8192;

  typedef enum logic [0:0] {
    CMD_PLACE   = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_INITIAL_WIDTH  = 2'd0,
    CFG_INITIAL_HEIGHT = 2'd1,
    CFG_MAX_WIDTH      = 2'd2,
    CFG_MAX_HEIGHT     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                    command;
    logic [SRP_DIM_BITS-1:0] rect_width;
    logic [SRP_DIM_BITS-1:0] rect_height;
  } srp_item_t;

  typedef struct packed {
    logic [SRP_OUT_BITS-1:0] place_x;
    logic [SRP_OUT_BITS-1:0] place_y;
    logic                    fits;
    logic [SRP_OUT_BITS-1:0] atlas_width_out;
    logic [SRP_OUT_BITS-1:0] atlas_height_out;
  } srp_result_t;

  // Configuration with the zero-means-default rule already applied.
  typedef struct packed {
    logic [SRP_DIM_BITS-1:0] init_w;
    logic [SRP_DIM_BITS-1:0] init_h;
    logic [SRP_DIM_BITS-1:0] max_w;
    logic [SRP_DIM_BITS-1:0] max_h;
  } srp_cfg_t;

endpackage

`default_nettype wire

// ===== sv/srp_if.sv =====
// Valid/ready channel interfaces for the packer's input and result words.
// Depends on srp_pkg for the field widths.
`default_nettype none

interface srp_in_if
  import srp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [SRP_DIM_BITS-1:0] rect_width;
  logic [SRP_DIM_BITS-1:0] rect_height;

  modport source (output valid, command, rect_width, rect_height, input ready);
  modport sink   (input valid, command, rect_width, rect_height, output ready);
  modport mon    (input valid, ready, command, rect_width, rect_height);
endinterface

interface srp_out_if
  import srp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [SRP_OUT_BITS-1:0] place_x;
  logic [SRP_OUT_BITS-1:0] place_y;
  logic                    fits;
  logic [SRP_OUT_BITS-1:0] atlas_width_out;
  logic [SRP_OUT_BITS-1:0] atlas_height_out;

  modport source (output valid, place_x, place_y, fits, atlas_width_out,
                  atlas_height_out, input ready);
  modport sink   (input valid, place_x, place_y, fits, atlas_width_out,
                  atlas_height_out, output ready);
  modport mon    (input valid, ready, place_x, place_y, fits, atlas_width_out,
                  atlas_height_out);
endinterface

`default_nettype wire

// ===== sv/shelf_rect_packer.sv =====
// Top level of the shelf rectangle packer: input word register, packing
// state, result register. Depends on srp_pkg, srp_if, srp_cfg_regs, srp_place.
`default_nettype none

// The packer takes one word per clock while the result is not stalled: a
// placement request or a restart. An accepted word is captured in the input
// register, then the placement logic resolves it combinationally against the
// cursor, shelf and atlas state and loads the result register, and a new word
// can follow in every cycle while the result is not stalled; the state update
// from one word to the next is registered with the result word. A stalled
// result holds the pipeline; the input stays ready while the input register
// is empty or the result register can move. Configuration writes take effect
// on the next clock and belong to idle periods.
module shelf_rect_packer
  import srp_pkg::*;
#(
  parameter int COORD_BITS = SRP_COORD_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  srp_in_if.sink                       in_chan,
  srp_out_if.source                    out_chan,
  input  wire logic                    cfg_we,
  input  wire cfg_idx_t                cfg_index,
  input  wire logic [SRP_DIM_BITS-1:0] cfg_wdata
);

  srp_cfg_t    cfg;
  srp_item_t   in_item_r;
  srp_result_t result, out_res_r;
  logic        in_vld_r, out_vld_r, advance;

  logic [COORD_BITS-1:0] cursor_x_r, cursor_y_r, shelf_h_r, atlas_w_r, atlas_h_r;
  logic [COORD_BITS-1:0] cursor_x_nxt, cursor_y_nxt, shelf_h_nxt, atlas_w_nxt, atlas_h_nxt;

  srp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srp_place #(.COORD_BITS(COORD_BITS)) u_place (
    .item         (in_item_r),
    .cfg          (cfg),
    .cursor_x     (cursor_x_r),
    .cursor_y     (cursor_y_r),
    .shelf_h      (shelf_h_r),
    .atlas_w      (atlas_w_r),
    .atlas_h      (atlas_h_r),
    .cursor_x_nxt (cursor_x_nxt),
    .cursor_y_nxt (cursor_y_nxt),
    .shelf_h_nxt  (shelf_h_nxt),
    .atlas_w_nxt  (atlas_w_nxt),
    .atlas_h_nxt  (atlas_h_nxt),
    .result       (result)
  );

  assign advance       = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.command     <= in_chan.command;
      in_item_r.rect_width  <= in_chan.rect_width;
      in_item_r.rect_height <= in_chan.rect_height;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      shelf_h_r  <= '0;
      atlas_w_r  <= '0;
      atlas_h_r  <= '0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
      if (in_vld_r) begin
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
        shelf_h_r  <= shelf_h_nxt;
        atlas_w_r  <= atlas_w_nxt;
        atlas_h_r  <= atlas_h_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_res_r <= result;
    end
  end

  assign out_chan.valid            = out_vld_r;
  assign out_chan.place_x          = out_res_r.place_x;
  assign out_chan.place_y          = out_res_r.place_y;
  assign out_chan.fits             = out_res_r.fits;
  assign out_chan.atlas_width_out  = out_res_r.atlas_width_out;
  assign out_chan.atlas_height_out = out_res_r.atlas_height_out;

endmodule

`default_nettype wire

// ===== sv/srp_cfg_regs.sv =====
// Configuration registers of the packer, with zero values mapped to defaults.
// Depends on srp_pkg.
`default_nettype none

module srp_cfg_regs
  import srp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire cfg_idx_t                cfg_index,
  input  wire logic [SRP_DIM_BITS-1:0] cfg_wdata,
  output srp_cfg_t                     cfg
);

  logic [SRP_DIM_BITS-1:0] init_w_r, init_h_r, max_w_r, max_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_w_r <= SRP_DIM_BITS'(SRP_DEFAULT_ATLAS);
      init_h_r <= SRP_DIM_BITS'(SRP_DEFAULT_ATLAS);
      max_w_r  <= SRP_DIM_BITS'(SRP_DEFAULT_MAX);
      max_h_r  <= SRP_DIM_BITS'(SRP_DEFAULT_MAX);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_WIDTH:  init_w_r <= cfg_wdata;
        CFG_INITIAL_HEIGHT: init_h_r <= cfg_wdata;
        CFG_MAX_WIDTH:      max_w_r  <= cfg_wdata;
        CFG_MAX_HEIGHT:     max_h_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A register written as zero behaves as its default.
  always_comb begin
    cfg.init_w = (init_w_r != '0) ? init_w_r : SRP_DIM_BITS'(SRP_DEFAULT_ATLAS);
    cfg.init_h = (init_h_r != '0) ? init_h_r : SRP_DIM_BITS'(SRP_DEFAULT_ATLAS);
    cfg.max_w  = (max_w_r  != '0) ? max_w_r  : SRP_DIM_BITS'(SRP_DEFAULT_MAX);
    cfg.max_h  = (max_h_r  != '0) ? max_h_r  : SRP_DIM_BITS'(SRP_DEFAULT_MAX);
  end

endmodule

`default_nettype wire

// ===== sv/srp_place.sv =====
// Placement logic: from the packing state, the configuration and one input
// word, the next packing state and the result word. Depends on srp_pkg.
`default_nettype none

module srp_place
  import srp_pkg::*;
#(
  parameter int COORD_BITS = SRP_COORD_BITS
) (
  input  wire srp_item_t               item,
  input  wire srp_cfg_t                cfg,
  input  wire logic [COORD_BITS-1:0]   cursor_x,
  input  wire logic [COORD_BITS-1:0]   cursor_y,
  input  wire logic [COORD_BITS-1:0]   shelf_h,
  input  wire logic [COORD_BITS-1:0]   atlas_w,
  input  wire logic [COORD_BITS-1:0]   atlas_h,
  output logic      [COORD_BITS-1:0]   cursor_x_nxt,
  output logic      [COORD_BITS-1:0]   cursor_y_nxt,
  output logic      [COORD_BITS-1:0]   shelf_h_nxt,
  output logic      [COORD_BITS-1:0]   atlas_w_nxt,
  output logic      [COORD_BITS-1:0]   atlas_h_nxt,
  output srp_result_t                  result
);

  // Exact arithmetic width: room for a doubled atlas plus a shelf and a
  // rectangle on top of a saturated coordinate.
  localparam int EB = ((COORD_BITS > SRP_DIM_BITS) ? COORD_BITS : SRP_DIM_BITS) + 3;

  function automatic logic [COORD_BITS-1:0] sat_c(input logic [EB-1:0] v);
    logic [COORD_BITS-1:0] r;
    if ((v >> COORD_BITS) != '0) r = '1;
    else                         r = v[COORD_BITS-1:0];
    return r;
  endfunction

  logic [COORD_BITS-1:0] w_res, h_res;
  logic [EB-1:0] w, h, rw, rh, mw, mh;
  logic [EB-1:0] cx1, cy1, sh1, cx2, cy2, sh2, w2, h2, cx3, sh3, w3, h3;
  logic          wide, wrap, grow, in_range, ok;

  always_comb begin
    w_res = (atlas_w != '0) ? atlas_w : sat_c(EB'(cfg.init_w));
    h_res = (atlas_h != '0) ? atlas_h : sat_c(EB'(cfg.init_h));
    w  = EB'(w_res);
    h  = EB'(h_res);
    rw = EB'(item.rect_width);
    rh = EB'(item.rect_height);
    mw = EB'(cfg.max_w);
    mh = EB'(cfg.max_h);

    wide = w > h;

    // Past the right edge: open a new shelf (right half on a wide atlas).
    wrap = (EB'(cursor_x) + rw) > w;
    cx1  = wrap ? (wide ? (w >> 1) : '0) : EB'(cursor_x);
    cy1  = wrap ? (EB'(cursor_y) + EB'(shelf_h)) : EB'(cursor_y);
    sh1  = wrap ? '0 : EB'(shelf_h);

    // Past the bottom: double the shorter side and start in the new space.
    grow = (cy1 + rh) > h;
    cx2  = grow ? (wide ? '0 : w) : cx1;
    cy2  = grow ? (wide ? h : '0) : cy1;
    sh2  = grow ? '0 : sh1;
    w2   = (grow && !wide) ? (w << 1) : w;
    h2   = (grow && wide)  ? (h << 1) : h;

    cx3 = cx2 + rw;
    sh3 = (sh2 > rh) ? sh2 : rh;
    w3  = (w2 > cx3) ? w2 : cx3;
    h3  = (h2 > (cy2 + sh3)) ? h2 : (cy2 + sh3);

    in_range = (rw <= mw) && (rh <= mh);
    ok       = in_range && (w3 <= mw) && (h3 <= mh);

    // Default: restart clears the cursor and leaves the stored atlas alone.
    cursor_x_nxt = '0;
    cursor_y_nxt = '0;
    shelf_h_nxt  = '0;
    atlas_w_nxt  = atlas_w;
    atlas_h_nxt  = atlas_h;
    result.place_x          = '0;
    result.place_y          = '0;
    result.fits             = 1'b0;
    result.atlas_width_out  = SRP_OUT_BITS'(w_res);
    result.atlas_height_out = SRP_OUT_BITS'(h_res);

    if (item.command == CMD_PLACE) begin
      if (in_range) begin
        cursor_x_nxt = sat_c(cx3);
        cursor_y_nxt = sat_c(cy2);
        shelf_h_nxt  = sat_c(sh3);
        atlas_w_nxt  = sat_c(w3);
        atlas_h_nxt  = sat_c(h3);
        result.place_x = ok ? cx2[SRP_OUT_BITS-1:0] : '0;
        result.place_y = ok ? cy2[SRP_OUT_BITS-1:0] : '0;
        result.fits    = ok;
      end else begin
        // Oversized rectangle: only the resolved atlas size is stored.
        cursor_x_nxt = cursor_x;
        cursor_y_nxt = cursor_y;
        shelf_h_nxt  = shelf_h;
        atlas_w_nxt  = w_res;
        atlas_h_nxt  = h_res;
      end
      result.atlas_width_out  = SRP_OUT_BITS'(atlas_w_nxt);
      result.atlas_height_out = SRP_OUT_BITS'(atlas_h_nxt);
    end
  end

endmodule

`default_nettype wire

// ===== sv/srp_checker.sv =====
// Port-level checks for the shelf rectangle packer and the bind that
// attaches them. Depends on srp_pkg, srp_if and shelf_rect_packer.
`default_nettype none

module srp_checker
  import srp_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  srp_in_if.sink    in_chan,
  srp_out_if.source out_chan
);

  // A result word waiting on the sink keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> out_chan.valid &&
      $stable(out_chan.place_x) && $stable(out_chan.place_y) &&
      $stable(out_chan.fits) && $stable(out_chan.atlas_width_out) &&
      $stable(out_chan.atlas_height_out))
    else $error("result word changed while stalled");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");

  // A failed or restart word reports the origin.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.fits |-> out_chan.place_x == '0 &&
      out_chan.place_y == '0)
    else $error("nonzero origin without fit");

  // A placed rectangle starts inside the reported atlas.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.fits |->
      out_chan.place_x <= out_chan.atlas_width_out &&
      out_chan.place_y <= out_chan.atlas_height_out &&
      out_chan.atlas_width_out != '0 && out_chan.atlas_height_out != '0)
    else $error("placement outside atlas");

  // An empty pipeline always takes a word.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid && !$past(in_chan.valid && in_chan.ready) |-> in_chan.ready)
    else $error("input stalled with empty pipeline");

endmodule

bind shelf_rect_packer srp_checker u_srp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);

`default_nettype wire
